// File: hw/rtl/mlfifo_pkg.sv
// shared types and constants for the multilevel fifo with rotating dequeue
`timescale 1ns / 1ps

package mlfifo_pkg;

    // fixed widths of the command, result and cfg fields
    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 4;

    // levels in use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_LENGTH  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEVEL = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

// File: hw/rtl/mlfifo_rot_pick.sv
// rotating find-first over the non-empty levels, starting at a given level
`timescale 1ns / 1ps

module mlfifo_rot_pick #(
    parameter int N  = 8,
    parameter int LW = 3
) (
    input  logic [N-1:0]  nonempty,
    input  logic [LW-1:0] start,
    output logic          found,
    output logic [LW-1:0] idx
);

    logic [N-1:0]  upper;
    logic [LW-1:0] up_idx;
    logic [LW-1:0] any_idx;

    always_comb
    begin
        upper   = '0;
        up_idx  = '0;
        any_idx = '0;
        // levels at or above the start level
        for (int l = 0; l < N; l++)
        begin
            upper[l] = nonempty[l] && (LW'(l) >= start);
        end
        for (int l = N - 1; l >= 0; l--)
        begin
            if (upper[l])
            begin
                up_idx = LW'(l);
            end
            if (nonempty[l])
            begin
                any_idx = LW'(l);
            end
        end
        found = |nonempty;
        // wrap to the lowest level when nothing lies above the start
        idx   = (|upper) ? up_idx : any_idx;
    end

endmodule

// File: hw/rtl/multilevel_fifo_rotating_dequeue_unit.sv
// top level of the multilevel fifo with rotating dequeue
//
// one fifo of LEVEL_DEPTH words per level, MAX_LEVELS levels, of which the
// first levels_in_use (cfg channel) are active
// command beat: taken at a clock edge with start high and busy low; busy is
// never raised, so a command may be issued in every cycle
// command 0 appends data_in at level, 1 takes the head of the first
// non-empty level searching upward from level and wrapping, 2 reports the
// count held at level
// result beat: every command gives exactly one, shown for one cycle with
// result_valid high from the edge after the command edge, taken at the next
// edge; the receiver cannot stall, a result must be taken as it appears
// latency is set by the command register and the registered store read,
// throughput is one command per cycle
// cfg beat: cfg_valid with cfg_ready (always high) writes levels_in_use;
// write only while no command is in flight
// reset empties every level and sets levels_in_use to 8; stored words are
// not cleared, an empty level is never read
`timescale 1ns / 1ps

module multilevel_fifo_rotating_dequeue_unit #(
    parameter int MAX_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16,
    parameter int ITEM_WIDTH  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [mlfifo_pkg::CMD_W-1:0]         command,
    input  logic [mlfifo_pkg::LEVEL_W-1:0]       level,
    input  logic [ITEM_WIDTH-1:0]                data_in,
    output logic                                 result_valid,
    output logic [mlfifo_pkg::STATUS_W-1:0]      status,
    output logic [ITEM_WIDTH-1:0]                data_out,
    output logic [mlfifo_pkg::LEVEL_W-1:0]       found_level,
    output logic [mlfifo_pkg::COUNT_W-1:0]       level_count,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mlfifo_pkg::CFG_W-1:0]         cfg_data
);

    localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int AW    = $clog2(MAX_LEVELS * LEVEL_DEPTH);
    localparam int DEPTH = MAX_LEVELS * LEVEL_DEPTH;
    localparam int ACT_W = ($clog2(MAX_LEVELS + 1) > mlfifo_pkg::CFG_W)
                           ? $clog2(MAX_LEVELS + 1) : mlfifo_pkg::CFG_W;

    // command register
    logic                               in_valid_reg;
    logic [mlfifo_pkg::CMD_W-1:0]       cmd_reg;
    logic [mlfifo_pkg::LEVEL_W-1:0]     lvl_reg;
    logic [ITEM_WIDTH-1:0]              din_reg;

    // level bookkeeping
    logic [mlfifo_pkg::CFG_W-1:0]       liu_reg;
    logic [PW-1:0]                      head_reg [MAX_LEVELS];
    logic [PW-1:0]                      tail_reg [MAX_LEVELS];
    logic [CW-1:0]                      fill_reg [MAX_LEVELS];
    logic [PW-1:0]                      head_next [MAX_LEVELS];
    logic [PW-1:0]                      tail_next [MAX_LEVELS];
    logic [CW-1:0]                      fill_next [MAX_LEVELS];

    // result register
    logic                               result_valid_reg;
    logic [mlfifo_pkg::STATUS_W-1:0]    status_reg;
    logic [mlfifo_pkg::STATUS_W-1:0]    status_next;
    logic [mlfifo_pkg::LEVEL_W-1:0]     found_reg;
    logic [mlfifo_pkg::LEVEL_W-1:0]     found_next;
    logic [mlfifo_pkg::COUNT_W-1:0]     count_reg;
    logic [mlfifo_pkg::COUNT_W-1:0]     count_next;
    logic [ITEM_WIDTH-1:0]              dout_reg;

    // item store
    logic [ITEM_WIDTH-1:0]              mem [DEPTH];
    logic                               wr_en;
    logic                               rd_en;
    logic [AW-1:0]                      addr;

    logic [ACT_W-1:0]                   liu_ext;
    logic [ACT_W-1:0]                   act;
    logic                               lvl_ok;
    logic [LW-1:0]                      lvl_idx;
    logic [MAX_LEVELS-1:0]              nonempty;
    logic                               pick_found;
    logic [LW-1:0]                      pick_idx;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign data_out     = dout_reg;
    assign found_level  = found_reg;
    assign level_count  = count_reg;

    assign liu_ext = ACT_W'(liu_reg);
    assign act     = (liu_ext > ACT_W'(MAX_LEVELS)) ? ACT_W'(MAX_LEVELS) : liu_ext;
    assign lvl_ok  = ACT_W'(lvl_reg) < act;
    assign lvl_idx = LW'(lvl_reg);

    always_comb
    begin
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            nonempty[l] = (ACT_W'(l) < act) && (fill_reg[l] != '0);
        end
    end

    mlfifo_rot_pick #(
        .N  (MAX_LEVELS),
        .LW (LW)
    ) u_pick (
        .nonempty (nonempty),
        .start    (lvl_idx),
        .found    (pick_found),
        .idx      (pick_idx)
    );

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        status_next = mlfifo_pkg::ST_OK;
        found_next  = '0;
        count_next  = '0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        addr        = AW'(lvl_idx) * AW'(LEVEL_DEPTH) + AW'(tail_reg[lvl_idx]);
        if (in_valid_reg)
        begin
            case (mlfifo_pkg::cmd_t'(cmd_reg))
                mlfifo_pkg::CMD_ENQUEUE:
                begin
                    if (!lvl_ok)
                    begin
                        status_next = mlfifo_pkg::ST_BAD_LEVEL;
                    end
                    else if (fill_reg[lvl_idx] == CW'(LEVEL_DEPTH))
                    begin
                        status_next = mlfifo_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en              = 1'b1;
                        tail_next[lvl_idx] = (tail_reg[lvl_idx] == PW'(LEVEL_DEPTH - 1))
                                             ? '0 : tail_reg[lvl_idx] + 1'b1;
                        fill_next[lvl_idx] = fill_reg[lvl_idx] + 1'b1;
                    end
                end
                mlfifo_pkg::CMD_DEQUEUE:
                begin
                    addr = AW'(pick_idx) * AW'(LEVEL_DEPTH) + AW'(head_reg[pick_idx]);
                    if (!lvl_ok)
                    begin
                        status_next = mlfifo_pkg::ST_BAD_LEVEL;
                    end
                    else if (!pick_found)
                    begin
                        status_next = mlfifo_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en               = 1'b1;
                        found_next          = mlfifo_pkg::LEVEL_W'(pick_idx);
                        head_next[pick_idx] = (head_reg[pick_idx] == PW'(LEVEL_DEPTH - 1))
                                              ? '0 : head_reg[pick_idx] + 1'b1;
                        fill_next[pick_idx] = fill_reg[pick_idx] - 1'b1;
                    end
                end
                mlfifo_pkg::CMD_LENGTH:
                begin
                    if (!lvl_ok)
                    begin
                        status_next = mlfifo_pkg::ST_BAD_LEVEL;
                    end
                    else
                    begin
                        count_next = mlfifo_pkg::COUNT_W'(fill_reg[lvl_idx]);
                    end
                end
                default:
                begin
                    status_next = mlfifo_pkg::ST_OK;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            liu_reg          <= mlfifo_pkg::CFG_RESET;
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                fill_reg[l] <= '0;
            end
        end
        else
        begin
            in_valid_reg     <= start && !busy;
            result_valid_reg <= in_valid_reg;
            if (cfg_valid && cfg_ready)
            begin
                liu_reg <= cfg_data;
            end
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= command;
            lvl_reg <= level;
            din_reg <= data_in;
        end
        status_reg <= status_next;
        found_reg  <= found_next;
        count_reg  <= count_next;
    end

    // item store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= din_reg;
        end
        if (rd_en)
        begin
            dout_reg <= mem[addr];
        end
        else
        begin
            dout_reg <= '0;
        end
    end

endmodule
